>>> rtl/core/pid_controller_clamped_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_ASSERT_SVH

// same-cycle implication
`define PCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// next-cycle implication
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`endif

>>> rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Register indexes, datapath command codes, shared types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = DATA_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd6;

  // opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // multiplier operand selects
  localparam logic [2:0] MS_E_DT      = 3'd0;
  localparam logic [2:0] MS_P_E       = 3'd1;
  localparam logic [2:0] MS_DIFF_RATE = 3'd2;
  localparam logic [2:0] MS_I_INTEG   = 3'd3;
  localparam logic [2:0] MS_D_DERIV   = 3'd4;

  localparam logic signed [PROD_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIM_W-1:0]         step_time;
    logic [LIM_W-1:0]         step_rate;
    logic [LIM_W-1:0]         integ_limit;
    logic [LIM_W-1:0]         out_limit;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       ld_integ;
    logic       ld_acc;
    logic       ld_deriv;
    logic       add_acc;
    logic       commit;
    logic       ld_out;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > S32_MAX) begin
      res = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      res = S32_MIN[DATA_W-1:0];
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
    logic signed [ACC_W-1:0] pos;
    logic signed [ACC_W-1:0] neg;
    logic signed [ACC_W-1:0] res;
    pos = $signed({3'b000, lim});
    neg = -pos;
    if (v > pos) begin
      res = pos;
    end else if (v < neg) begin
      res = neg;
    end else begin
      res = v;
    end
    return res[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/core/pcc_if.sv
// ----------------------------------------------------------------------------
// PID controller channels
// Valid/ready channels for update items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcc_in_if import pcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] err_sample;

  modport source (output valid, output opcode, output err_sample, input ready);
  modport sink (input valid, input opcode, input err_sample, output ready);
endinterface

interface pcc_out_if import pcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     active;

  modport source (output valid, output drive, output active, input ready);
  modport sink (input valid, input drive, input active, output ready);
endinterface

interface pcc_cfg_if import pcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// PID controller register file
// Gains, sample period, its reciprocal and the two clamp limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_cfg_regs import pcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        REG_GAIN_P:      cfg_nxt.gain_p      = $signed(wr_data);
        REG_GAIN_I:      cfg_nxt.gain_i      = $signed(wr_data);
        REG_GAIN_D:      cfg_nxt.gain_d      = $signed(wr_data);
        REG_STEP_TIME:   cfg_nxt.step_time   = wr_data[LIM_W-1:0];
        REG_STEP_RATE:   cfg_nxt.step_rate   = wr_data[LIM_W-1:0];
        REG_INTEG_LIMIT: cfg_nxt.integ_limit = wr_data[LIM_W-1:0];
        REG_OUT_LIMIT:   cfg_nxt.out_limit   = wr_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.step_time   <= 31'd655;
      cfg_r.step_rate   <= 31'd6553600;
      cfg_r.integ_limit <= 31'd65536;
      cfg_r.out_limit   <= 31'h7FFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/pcc_datapath.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// One shared 32x32 multiplier, scale and saturate, accumulator and clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcc_datapath import pcc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  cfg_t                     cfg,
  input  logic signed [DATA_W-1:0] err_sample,
  output logic signed [DATA_W-1:0] drive,
  output logic                     active
);

  localparam logic signed [DATA_W-1:0] ACT_THRESH =
    DATA_W'(((1 << FRAC_BITS) + 9999) / 10000);

  logic signed [DATA_W-1:0] e_r,        e_nxt;
  logic signed [DATA_W-1:0] integral_r, integral_nxt;
  logic signed [DATA_W-1:0] last_err_r, last_err_nxt;
  logic signed [DATA_W-1:0] integ_r,    integ_nxt;
  logic signed [DATA_W-1:0] diff_r,     diff_nxt;
  logic signed [DATA_W-1:0] deriv_r,    deriv_nxt;
  logic signed [PROD_W-1:0] prod_r,     prod_nxt;
  logic signed [ACC_W-1:0]  acc_r,      acc_nxt;
  logic signed [DATA_W-1:0] drive_r,    drive_nxt;
  logic                     active_r,   active_nxt;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] scaled;
  logic                     act;

  assign drive  = drive_r;
  assign active = active_r;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MS_E_DT: begin
        mul_a = e_r;
        mul_b = $signed({1'b0, cfg.step_time});
      end
      MS_P_E: begin
        mul_a = cfg.gain_p;
        mul_b = e_r;
      end
      MS_DIFF_RATE: begin
        mul_a = diff_r;
        mul_b = $signed({1'b0, cfg.step_rate});
      end
      MS_I_INTEG: begin
        mul_a = cfg.gain_i;
        mul_b = integ_r;
      end
      MS_D_DERIV: begin
        mul_a = cfg.gain_d;
        mul_b = deriv_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign scaled = sat32(prod_r >>> FRAC_BITS);
  assign act    = (cfg.gain_p >= ACT_THRESH) || (cfg.gain_i >= ACT_THRESH) ||
                  (cfg.gain_d >= ACT_THRESH);

  always_comb begin
    e_nxt        = e_r;
    integral_nxt = integral_r;
    last_err_nxt = last_err_r;
    integ_nxt    = integ_r;
    diff_nxt     = diff_r;
    deriv_nxt    = deriv_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    drive_nxt    = drive_r;
    active_nxt   = active_r;

    if (cmd.capture) begin
      e_nxt = err_sample;
    end
    if (cmd.clear) begin
      integral_nxt = '0;
      last_err_nxt = '0;
      acc_nxt      = '0;
    end
    if (cmd.mul_en) begin
      prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.ld_integ) begin
      integ_nxt = sat32(PROD_W'(integral_r) + PROD_W'(scaled));
      diff_nxt  = sat32(PROD_W'(e_r) - PROD_W'(last_err_r));
    end
    if (cmd.ld_acc) begin
      acc_nxt = ACC_W'(scaled);
    end
    if (cmd.ld_deriv) begin
      deriv_nxt = scaled;
    end
    if (cmd.add_acc) begin
      acc_nxt = acc_r + ACC_W'(scaled);
    end
    if (cmd.commit) begin
      integral_nxt = clamp_sym(ACC_W'(integ_r), cfg.integ_limit);
      last_err_nxt = e_r;
    end
    if (cmd.ld_out) begin
      drive_nxt  = clamp_sym(acc_r, cfg.out_limit);
      active_nxt = act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      last_err_r <= '0;
    end else begin
      integral_r <= integral_nxt;
      last_err_r <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    integ_r  <= integ_nxt;
    diff_r   <= diff_nxt;
    deriv_r  <= deriv_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    drive_r  <= drive_nxt;
    active_r <= active_nxt;
  end

endmodule

>>> rtl/core/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through one update or clear item and owns both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_controller_clamped_assert.svh"

module pcc_ctrl import pcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_S4   = 3'd4;
  localparam logic [2:0] ST_S5   = 3'd5;
  localparam logic [2:0] ST_S6   = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_fire;
        cmd.clear   = in_fire && (in_opcode == OP_CLEAR);
        if (in_fire) begin
          state_nxt = (in_opcode == OP_CLEAR) ? ST_FIN : ST_S1;
        end
      end
      ST_S1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_E_DT;
        state_nxt   = ST_S2;
      end
      ST_S2: begin
        cmd.ld_integ = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_P_E;
        state_nxt    = ST_S3;
      end
      ST_S3: begin
        cmd.ld_acc  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DIFF_RATE;
        state_nxt   = ST_S4;
      end
      ST_S4: begin
        cmd.ld_deriv = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_I_INTEG;
        state_nxt    = ST_S5;
      end
      ST_S5: begin
        cmd.add_acc = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_D_DERIV;
        state_nxt   = ST_S6;
      end
      ST_S6: begin
        cmd.add_acc = 1'b1;
        cmd.commit  = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        cmd.ld_out = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PCC_ASSERT_NEXT(a_clear_to_fin, in_fire && (in_opcode == OP_CLEAR), state_r == ST_FIN)
  `PCC_ASSERT_NEXT(a_update_starts, in_fire && (in_opcode == OP_UPDATE), state_r == ST_S1)
  `PCC_ASSERT_NEXT(a_fin_holds, (state_r == ST_FIN) && out_valid_r && !out_ready, state_r == ST_FIN)
  `PCC_ASSERT_SAME(a_one_load, cmd.ld_out, (state_r == ST_FIN) && slot_free)
  `PCC_ASSERT_NEXT(a_result_after_load, cmd.ld_out, out_valid_r && (state_r == ST_IDLE))

endmodule

>>> rtl/core/pid_controller_clamped.sv
// An update item passes from its transfer through states S1 to S6 and FIN to its result,
//   a clear item from its transfer straight to FIN. A new item is taken only in idle, and
//   the single shared 32x32 multiplier is stepped through five products by the sequencer.
// The result register lets the next item transfer in while the last result still waits.
// Reset (rst_n, synchronous): config registers return to defaults, integral and last error clear.
// ----------------------------------------------------------------------------
// PID controller with clamped integral and output
// Positional fixed-point PID: sequencer, shared datapath and register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_controller_clamped import pcc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  pcc_in_if.sink    in_if,
  pcc_out_if.source out_if,
  pcc_cfg_if.sink   cfg_if
);

  cfg_t cfg;
  cmd_t cmd;
  logic out_valid;
  logic in_ready;

  pcc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_ready (cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  pcc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .err_sample (in_if.err_sample),
    .drive      (out_if.drive),
    .active     (out_if.active)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives update and clear items and register writes through the valid/ready
// channels, predicts drive/active results in a fixed-point model of the
// controller, or fixed per row, and checks each result transfer in order.
// ----------------------------------------------------------------------------

module testbench import pcc_pkg::*; ();

  localparam int FRAC    = 16;
  localparam int ACT_MIN = ((1 << FRAC) + 9999) / 10000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     active;
  } pid_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic                     op;
    logic [DATA_W-1:0]        val;
    logic                     typed;
    logic signed [DATA_W-1:0] exp_drive;
    logic                     exp_active;
  } plan_row_t;

  logic clk;
  logic rst_n;

  pcc_in_if  in_ch();
  pcc_out_if out_ch();
  pcc_cfg_if cfg_ch();

  pid_controller_clamped #(.FRAC_BITS(FRAC)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // controller model state
  logic signed [DATA_W-1:0] kp, ki, kd;
  logic [LIM_W-1:0]         dt, inv_dt, integ_lim, drive_lim;
  logic signed [DATA_W-1:0] integ_acc, prev_err;

  pid_result_t drive_q[$];
  pid_result_t head;
  plan_row_t   plan[$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  logic        cfg_open;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DATA_W-1:0] sat_word(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_word(p >>> FRAC);
  endfunction

  function automatic longint clamp_mag(input longint v, input logic [LIM_W-1:0] lim);
    longint m;
    m = longint'({1'b0, lim});
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val);
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_STEP_TIME: dt = val[LIM_W-1:0];
      REG_STEP_RATE: inv_dt = val[LIM_W-1:0];
      REG_INTEG_LIMIT: integ_lim = val[LIM_W-1:0];
      REG_OUT_LIMIT: drive_lim = val[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic pid_result_t step_pid(input logic op, input logic signed [DATA_W-1:0] e);
    pid_result_t r;
    logic signed [DATA_W-1:0] integ, diff, deriv;
    longint sum;
    r.active = (kp >= ACT_MIN) || (ki >= ACT_MIN) || (kd >= ACT_MIN);
    r.drive = '0;
    if (op == OP_CLEAR) begin
      integ_acc = '0;
      prev_err = '0;
    end else begin
      integ = sat_word(longint'(integ_acc) + longint'(qmul(longint'(e), longint'(dt))));
      diff = sat_word(longint'(e) - longint'(prev_err));
      deriv = qmul(longint'(diff), longint'(inv_dt));
      sum = longint'(qmul(longint'(kp), longint'(e))) +
            longint'(qmul(longint'(ki), longint'(integ))) +
            longint'(qmul(longint'(kd), longint'(deriv)));
      integ_acc = DATA_W'(clamp_mag(longint'(integ), integ_lim));
      r.drive = DATA_W'(clamp_mag(sum, drive_lim));
      prev_err = e;
    end
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [DATA_W-1:0] e);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.val = e;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic op, input logic [DATA_W-1:0] e,
                                          input logic [DATA_W-1:0] drv, input logic act);
    plan_row_t r;
    r = item_row(op, e);
    r.typed = 1'b1;
    r.exp_drive = drv;
    r.exp_active = act;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 18) - (1 << 17);
      2: return $urandom_range(0, 10);
      3: return -$urandom_range(0, 10);
      4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 1 << 17);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_span();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 17);
      2: return {1'($urandom_range(1)), 31'd0};
      3: return {1'($urandom_range(1)), 31'h7fffffff};
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_err();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      9: return $urandom_range(0, 512) - 256;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] e,
                           input logic typed, input pid_result_t fixed);
    pid_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.err_sample <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = step_pid(op, e);
    if (typed) want = fixed;
    drive_q.push_back(want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    load_reg(idx, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("unexpected result transfer: drive %0d active %0d", out_ch.drive,
               out_ch.active);
        mismatches++;
      end else begin
        head = drive_q.pop_front();
        if (out_ch.drive !== head.drive) begin
          $error("drive: expected %0d, actual %0d", head.drive, out_ch.drive);
          mismatches++;
        end
        if (out_ch.active !== head.active) begin
          $error("active: expected %0d, actual %0d", head.active, out_ch.active);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    pid_result_t fixed;
    plan_row_t   r;
    int          ph;
    int          n;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_UPDATE;
    in_ch.err_sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GAIN_P;
    cfg_ch.data = '0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    cfg_open = 1'b0;

    kp = '0;
    ki = '0;
    kd = '0;
    dt = 31'd655;
    inv_dt = 31'd6553600;
    integ_lim = 31'd65536;
    drive_lim = 31'h7fffffff;
    integ_acc = '0;
    prev_err = '0;

    // directed plan
    plan.push_back(known_row(OP_UPDATE, 32'h7fffffff, 32'd0, 1'b0));
    plan.push_back(known_row(OP_UPDATE, 32'h80000000, 32'd0, 1'b0));
    plan.push_back(known_row(OP_CLEAR, 32'h12345678, 32'd0, 1'b0));
    plan.push_back(reg_row(REG_GAIN_P, 32'h00010000));
    plan.push_back(known_row(OP_UPDATE, 32'd12345, 32'd12345, 1'b1));
    plan.push_back(known_row(OP_UPDATE, 32'h7fffffff, 32'h7fffffff, 1'b1));
    plan.push_back(known_row(OP_UPDATE, 32'h80000000, 32'h80000001, 1'b1));
    plan.push_back(reg_row(REG_GAIN_P, 32'h7fffffff));
    plan.push_back(reg_row(REG_GAIN_I, 32'h80000000));
    plan.push_back(reg_row(REG_GAIN_D, 32'd7));
    plan.push_back(reg_row(REG_UNUSED, 32'hffffffff));
    plan.push_back(item_row(OP_UPDATE, 32'hffffffff));
    plan.push_back(item_row(OP_UPDATE, 32'h7fffffff));
    plan.push_back(item_row(OP_UPDATE, 32'h80000000));
    plan.push_back(known_row(OP_CLEAR, 32'hffffffff, 32'd0, 1'b1));
    plan.push_back(reg_row(REG_GAIN_P, 32'd6));
    plan.push_back(reg_row(REG_GAIN_I, 32'hffffffff));
    plan.push_back(reg_row(REG_GAIN_D, 32'h80000000));
    plan.push_back(reg_row(REG_STEP_TIME, 32'hffffffff));
    plan.push_back(reg_row(REG_STEP_RATE, 32'h7fffffff));
    plan.push_back(reg_row(REG_INTEG_LIMIT, 32'd0));
    plan.push_back(item_row(OP_UPDATE, 32'h7fffffff));
    plan.push_back(item_row(OP_UPDATE, 32'h80000000));
    plan.push_back(item_row(OP_UPDATE, 32'd1));
    plan.push_back(known_row(OP_CLEAR, 32'd0, 32'd0, 1'b0));
    plan.push_back(reg_row(REG_STEP_TIME, 32'd0));
    plan.push_back(reg_row(REG_STEP_RATE, 32'd0));
    plan.push_back(reg_row(REG_INTEG_LIMIT, 32'h7fffffff));
    plan.push_back(reg_row(REG_OUT_LIMIT, 32'd0));
    plan.push_back(known_row(OP_UPDATE, 32'h7fffffff, 32'd0, 1'b0));
    plan.push_back(reg_row(REG_GAIN_P, 32'h00008000));
    plan.push_back(reg_row(REG_GAIN_I, 32'h00020000));
    plan.push_back(reg_row(REG_GAIN_D, 32'h00000100));
    plan.push_back(reg_row(REG_STEP_TIME, 32'h00010000));
    plan.push_back(reg_row(REG_STEP_RATE, 32'h00010000));
    plan.push_back(reg_row(REG_INTEG_LIMIT, 32'h00030000));
    plan.push_back(reg_row(REG_OUT_LIMIT, 32'h00080000));
    plan.push_back(item_row(OP_UPDATE, 32'h00040000));
    plan.push_back(item_row(OP_UPDATE, 32'h00040000));
    plan.push_back(item_row(OP_UPDATE, 32'hfffc0000));
    plan.push_back(item_row(OP_UPDATE, 32'd0));
    plan.push_back(item_row(OP_UPDATE, 32'd3));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_REG) begin
        if (!cfg_open) drain();
        write_reg(r.idx, r.val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        fixed.drive = r.exp_drive;
        fixed.active = r.exp_active;
        send_item(r.op, r.val, r.typed, fixed);
      end
    end

    // random phases, each with fresh settings and one of four idle/stall mixes
    fixed = '0;
    for (ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_STEP_TIME, rand_span());
      write_reg(REG_STEP_RATE, rand_span());
      write_reg(REG_INTEG_LIMIT, rand_span());
      write_reg(REG_OUT_LIMIT, $urandom_range(3) == 0 ? rand_span() : $urandom);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
      cfg_ch.valid <= 1'b0;
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      for (n = 0; n < 137; n++) begin
        send_item(($urandom_range(19) == 0) ? OP_CLEAR : OP_UPDATE, rand_err(), 1'b0, fixed);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
